>>> rtl/epfw_pkg.sv
// Shared constants, codes and types for the epoch fence witness table.
package epfw_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = 11;
    localparam int HOR_W       = 21;
    localparam int CFG_IDX_W   = 2;
    localparam logic [HOR_W-1:0] HORIZON_MAX = HOR_W'(1048576);
    localparam logic [CNT_W-1:0] DEPTH_LIMIT = CNT_W'(TABLE_DEPTH);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZON  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SUBJ = 2'd1;

    // result status codes
    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_NO_DOMAIN  = 4'd1,
        ST_NO_SCOPE   = 4'd2,
        ST_NO_IDS     = 4'd3,
        ST_NO_STEP    = 4'd4,
        ST_CLOCK_OVF  = 4'd5,
        ST_REGRESSION = 4'd6,
        ST_INC_CONF   = 4'd7,
        ST_FENCE_CONF = 4'd8,
        ST_FULL       = 4'd9,
        ST_SEQ_OVF    = 4'd10
    } t_status;

    // one table entry as stored in the RAM
    typedef struct packed {
        logic [63:0] key;
        logic [31:0] epoch;
        logic [31:0] incarnation;
        logic [31:0] fence;
        logic [31:0] generation;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

>>> rtl/epoch_fence_witness_table_top.sv
// Top level of the epoch fence witness table: sequencer, table scan and result registers.
//
// Usage: pulse i_start with a request on the i_ ports while o_busy is low; the item
// is taken at that edge and o_busy rises. One result comes back on the o_ ports,
// marked by o_result_valid for exactly one cycle; the receiver cannot stall it.
// Configuration goes through i_cfg_valid/o_cfg_ready (always ready), i_cfg_index
// and i_cfg_data; index 0 is the attestation horizon, 1 the subject limit.
// A request refused on its presence flags or clock is answered from the check
// state. Otherwise the table is scanned one entry at a time through the single
// RAM port, each entry read in S_RD and compared in S_CMP, and the scan stops at
// a key match or at the last of the entries in use (up to 1024); the next item
// is taken in the cycle of the result strobe.
// Entries are filled in order and never removed, so the fill count marks the
// valid region; the table needs no clearing pass after reset.
// Reset (i_rst_n low, synchronous) empties the table, zeroes the sequence and
// logical clock and restores the horizon to 1024 and the limit to 1024.
module epoch_fence_witness_table_top
    import epfw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [HOR_W-1:0]     i_cfg_data,
    input  logic [63:0]          i_subject_key,
    input  logic                 i_domain_present,
    input  logic                 i_scope_present,
    input  logic                 i_ids_present,
    input  logic [31:0]          i_epoch,
    input  logic [31:0]          i_incarnation,
    input  logic [31:0]          i_fence_token,
    input  logic                 i_step_present,
    input  logic [31:0]          i_requester_step,
    input  logic [31:0]          i_policy_generation,
    input  logic [31:0]          i_requested_at,
    output logic                 o_result_valid,
    output logic [3:0]           o_status_code,
    output logic [31:0]          o_detail,
    output logic [31:0]          o_subject_generation,
    output logic [31:0]          o_attest_seq,
    output logic [31:0]          o_window_start,
    output logic [31:0]          o_window_end,
    output logic [31:0]          o_policy_generation_out,
    output logic [31:0]          o_echo_time
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CHK  = 5'b00010,
        S_RD   = 5'b00100,
        S_CMP  = 5'b01000,
        S_DEC  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // latched request
    logic [63:0] r_key;
    logic [3:0]  r_flags;
    logic [31:0] r_epoch, r_inc, r_fence, r_step, r_pol, r_req_at;

    // block state
    logic [HOR_W-1:0] r_horizon;
    logic [CNT_W-1:0] r_max_subj;
    logic [CNT_W-1:0] r_used, n_used;
    logic [31:0]      r_seq, n_seq;
    logic [31:0]      r_lclk, n_lclk;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_found, n_found;

    // result registers
    logic        r_ovalid, n_ovalid;
    t_status     r_status, n_status;
    logic [31:0] r_detail, n_detail, r_gen, n_gen, r_wseq, n_wseq;
    logic [31:0] r_issued, n_issued, r_until, n_until, r_opol, n_opol, r_oat, n_oat;

    // RAM port
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_addr;
    t_entry           ram_wdata, ram_rdata;

    // window end and limit helpers
    logic [HOR_W-1:0] hor_sat;
    logic [32:0]      end_sum;
    logic [31:0]      end_sat;
    logic [CNT_W-1:0] limit;
    logic             last_idx;

    epfw_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_re   (ram_re),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign hor_sat  = (r_horizon > HORIZON_MAX) ? HORIZON_MAX : r_horizon;
    assign end_sum  = {1'b0, r_step} + {12'd0, hor_sat};
    assign end_sat  = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
    assign limit    = (r_max_subj > DEPTH_LIMIT) ? DEPTH_LIMIT : r_max_subj;
    assign last_idx = ({1'b0, r_idx} + CNT_W'(1)) == r_used;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_seq     = r_seq;
        n_lclk    = r_lclk;
        n_idx     = r_idx;
        n_found   = r_found;
        n_ovalid  = 1'b0;
        n_status  = r_status;
        n_detail  = r_detail;
        n_gen     = r_gen;
        n_wseq    = r_wseq;
        n_issued  = r_issued;
        n_until   = r_until;
        n_opol    = r_opol;
        n_oat     = r_oat;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = r_idx;
        ram_wdata = ram_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_idx   = '0;
                n_found = 1'b0;
                n_detail = '0; n_gen = '0; n_wseq = '0;
                n_issued = '0; n_until = '0; n_opol = '0; n_oat = '0;
                priority if (!r_flags[3]) begin
                    n_ovalid = 1'b1; n_status = ST_NO_DOMAIN; n_state = S_IDLE;
                end else if (!r_flags[2]) begin
                    n_ovalid = 1'b1; n_status = ST_NO_SCOPE; n_state = S_IDLE;
                end else if (!r_flags[1]) begin
                    n_ovalid = 1'b1; n_status = ST_NO_IDS; n_state = S_IDLE;
                end else if (!r_flags[0]) begin
                    n_ovalid = 1'b1; n_status = ST_NO_STEP; n_state = S_IDLE;
                end else if (r_lclk == 32'hFFFF_FFFF) begin
                    n_ovalid = 1'b1; n_status = ST_CLOCK_OVF; n_state = S_IDLE;
                end else begin
                    n_lclk  = r_lclk + 32'd1;
                    n_state = (r_used == '0) ? S_DEC : S_RD;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                // read data of entry r_idx stays held until the next read
                if (ram_rdata.key == r_key) begin
                    n_found = 1'b1;
                    n_state = S_DEC;
                end else if (last_idx) begin
                    n_state = S_DEC;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_RD;
                end
            end
            S_DEC: begin
                n_ovalid = 1'b1;
                n_state  = S_IDLE;
                priority if (r_found && r_epoch < ram_rdata.epoch) begin
                    n_status = ST_REGRESSION; n_detail = ram_rdata.epoch;
                end else if (r_found && r_epoch == ram_rdata.epoch
                             && r_inc != ram_rdata.incarnation) begin
                    n_status = ST_INC_CONF; n_detail = ram_rdata.incarnation;
                end else if (r_found && r_epoch == ram_rdata.epoch
                             && r_fence != ram_rdata.fence) begin
                    n_status = ST_FENCE_CONF; n_detail = ram_rdata.fence;
                end else if (!r_found && r_used >= limit) begin
                    n_status = ST_FULL; n_detail = {21'd0, r_used};
                end else if (r_seq == 32'hFFFF_FFFF) begin
                    n_status = ST_SEQ_OVF;
                end else begin
                    // upsert the entry
                    ram_we                = 1'b1;
                    ram_addr              = r_found ? r_idx : r_used[IDX_W-1:0];
                    ram_wdata.key         = r_key;
                    ram_wdata.epoch       = r_epoch;
                    ram_wdata.incarnation = r_inc;
                    ram_wdata.fence       = r_fence;
                    ram_wdata.generation  = r_found ? ram_rdata.generation + 32'd1 : 32'd1;
                    if (!r_found) begin
                        n_used = r_used + CNT_W'(1);
                    end
                    n_seq    = r_seq + 32'd1;
                    n_status = ST_OK;
                    n_gen    = ram_wdata.generation;
                    n_wseq   = r_seq + 32'd1;
                    n_issued = r_step;
                    n_until  = end_sat;
                    n_opol   = r_pol;
                    n_oat    = r_req_at;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_used     <= '0;
            r_seq      <= '0;
            r_lclk     <= '0;
            r_ovalid   <= 1'b0;
            r_horizon  <= HOR_W'(1024);
            r_max_subj <= CNT_W'(1024);
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_seq    <= n_seq;
            r_lclk   <= n_lclk;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_HORIZON) begin
                    r_horizon <= i_cfg_data;
                end else if (i_cfg_index == CFG_MAX_SUBJ) begin
                    r_max_subj <= i_cfg_data[CNT_W-1:0];
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_key    <= i_subject_key;
            r_flags  <= {i_domain_present, i_scope_present, i_ids_present, i_step_present};
            r_epoch  <= i_epoch;
            r_inc    <= i_incarnation;
            r_fence  <= i_fence_token;
            r_step   <= i_requester_step;
            r_pol    <= i_policy_generation;
            r_req_at <= i_requested_at;
        end
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_status <= n_status;
        r_detail <= n_detail;
        r_gen    <= n_gen;
        r_wseq   <= n_wseq;
        r_issued <= n_issued;
        r_until  <= n_until;
        r_opol   <= n_opol;
        r_oat    <= n_oat;
    end

    assign o_result_valid          = r_ovalid;
    assign o_status_code           = r_status;
    assign o_detail                = r_detail;
    assign o_subject_generation    = r_gen;
    assign o_attest_seq            = r_wseq;
    assign o_window_start          = r_issued;
    assign o_window_end            = r_until;
    assign o_policy_generation_out = r_opol;
    assign o_echo_time             = r_oat;
endmodule

>>> rtl/epfw_ram.sv
// Generic single-port RAM with registered read.
module epfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/epfw_checker.sv
// Port-level assertions for the epoch fence witness table, bound to the top level.
module epfw_checker
    import epfw_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        i_domain_present,
    input logic        o_result_valid,
    input logic [3:0]  o_status_code,
    input logic [31:0] o_subject_generation,
    input logic [31:0] o_window_start,
    input logic [31:0] o_window_end
);
    // an accepted item keeps the block busy in the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("busy did not rise after accept");

    // a missing domain is refused with the no-domain status from the check state
    a_no_domain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_domain_present) |=> ##1
            (o_result_valid && o_status_code == ST_NO_DOMAIN))
        else $error("no-domain refusal missing");

    // status codes stay within the defined set
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_status_code <= ST_SEQ_OVF))
        else $error("undefined status");

    // a granted window never ends before it starts and has a generation
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status_code == ST_OK) |->
            (o_window_end >= o_window_start && o_subject_generation != 32'd0))
        else $error("bad window or generation");

    // refusals carry no generation
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status_code != ST_OK) |-> (o_subject_generation == 32'd0))
        else $error("refusal carries generation");
endmodule

bind epoch_fence_witness_table_top epfw_checker u_epfw_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_start             (i_start),
    .o_busy              (o_busy),
    .i_domain_present    (i_domain_present),
    .o_result_valid      (o_result_valid),
    .o_status_code       (o_status_code),
    .o_subject_generation(o_subject_generation),
    .o_window_start      (o_window_start),
    .o_window_end        (o_window_end)
);

>>> tb/epoch_fence_witness_table_top_test.sv
// Self-checking testbench for the epoch fence witness table top level.
module epoch_fence_witness_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import epfw_pkg::*;

    localparam int STALL_LIMIT = 50000;
    localparam int NUM_KEYS    = 40;
    localparam logic [31:0] ALL32 = 32'hFFFF_FFFF;

    typedef struct {
        logic [63:0] key;
        logic        dom;
        logic        scp;
        logic        ids;
        logic        stp;
        logic [31:0] epoch;
        logic [31:0] inc;
        logic [31:0] fence;
        logic [31:0] step;
        logic [31:0] pol;
        logic [31:0] req_at;
    } t_req;

    typedef struct {
        t_status     status;
        logic [31:0] detail;
        logic [31:0] gen;
        logic [31:0] seq;
        logic [31:0] issued;
        logic [31:0] win_end;
        logic [31:0] pol;
        logic [31:0] observed;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [HOR_W-1:0] i_cfg_data = '0;
    logic [63:0] i_subject_key = '0;
    logic i_domain_present = 1'b0;
    logic i_scope_present = 1'b0;
    logic i_ids_present = 1'b0;
    logic [31:0] i_epoch = '0;
    logic [31:0] i_incarnation = '0;
    logic [31:0] i_fence_token = '0;
    logic i_step_present = 1'b0;
    logic [31:0] i_requester_step = '0;
    logic [31:0] i_policy_generation = '0;
    logic [31:0] i_requested_at = '0;
    logic o_result_valid;
    logic [3:0] o_status_code;
    logic [31:0] o_detail, o_subject_generation, o_attest_seq, o_window_start;
    logic [31:0] o_window_end, o_policy_generation_out, o_echo_time;

    epoch_fence_witness_table_top u_dut (.*);

    always #10 i_clk = ~i_clk;

    // witness state mirror
    logic [31:0] tbl_epoch [logic [63:0]];
    logic [31:0] tbl_inc   [logic [63:0]];
    logic [31:0] tbl_fence [logic [63:0]];
    logic [31:0] tbl_gen   [logic [63:0]];
    int unsigned subjects_used = 0;
    logic [31:0] seq_last = '0;
    logic [31:0] lclock = '0;
    logic [20:0] horizon_reg = 21'd1024;
    logic [10:0] subj_limit_reg = 11'd1024;

    t_req     pending_q[$];
    t_verdict verdict_q[$];
    logic [63:0] key_pool [NUM_KEYS];
    int   idle_pct = 0;
    int   errors = 0;
    int   stall_cnt = 0;
    logic took_item = 1'b0;

    // compute the witness verdict for one request and update the mirror
    function automatic t_verdict witness_verdict(t_req r);
        t_verdict v;
        logic [31:0] lim, hor;
        logic [32:0] wend;
        bit found;
        v = '{status: ST_OK, default: '0};
        if (!r.dom) begin v.status = ST_NO_DOMAIN; return v; end
        if (!r.scp) begin v.status = ST_NO_SCOPE; return v; end
        if (!r.ids) begin v.status = ST_NO_IDS; return v; end
        if (!r.stp) begin v.status = ST_NO_STEP; return v; end
        if (lclock == ALL32) begin v.status = ST_CLOCK_OVF; return v; end
        lclock++;
        found = tbl_epoch.exists(r.key);
        if (found) begin
            if (r.epoch < tbl_epoch[r.key]) begin
                v.status = ST_REGRESSION; v.detail = tbl_epoch[r.key]; return v;
            end
            if (r.epoch == tbl_epoch[r.key] && r.inc != tbl_inc[r.key]) begin
                v.status = ST_INC_CONF; v.detail = tbl_inc[r.key]; return v;
            end
            if (r.epoch == tbl_epoch[r.key] && r.fence != tbl_fence[r.key]) begin
                v.status = ST_FENCE_CONF; v.detail = tbl_fence[r.key]; return v;
            end
        end else begin
            lim = (subj_limit_reg > TABLE_DEPTH) ? TABLE_DEPTH : subj_limit_reg;
            if (subjects_used >= lim) begin
                v.status = ST_FULL; v.detail = subjects_used; return v;
            end
        end
        if (seq_last == ALL32) begin v.status = ST_SEQ_OVF; return v; end
        seq_last++;
        if (found) tbl_gen[r.key] = tbl_gen[r.key] + 1;
        else begin
            tbl_gen[r.key] = 1;
            subjects_used++;
        end
        tbl_epoch[r.key] = r.epoch;
        tbl_inc[r.key] = r.inc;
        tbl_fence[r.key] = r.fence;
        hor = (horizon_reg > HORIZON_MAX) ? 32'(HORIZON_MAX) : 32'(horizon_reg);
        wend = {1'b0, r.step} + {1'b0, hor};
        v.gen = tbl_gen[r.key];
        v.seq = seq_last;
        v.issued = r.step;
        v.win_end = wend[32] ? ALL32 : wend[31:0];
        v.pol = r.pol;
        v.observed = r.req_at;
        return v;
    endfunction

    function automatic t_req mk(logic [63:0] key, logic [3:0] flags, logic [31:0] ep,
                                logic [31:0] inc, logic [31:0] fn, logic [31:0] step);
        t_req r;
        r.key = key;
        {r.dom, r.scp, r.ids, r.stp} = flags;
        r.epoch = ep; r.inc = inc; r.fence = fn; r.step = step;
        r.pol = $urandom; r.req_at = $urandom;
        return r;
    endfunction

    // mostly well-formed claims on a small key set so conflicts are frequent
    function automatic t_req rand_req();
        t_req r;
        logic [3:0] flags;
        logic [63:0] key;
        flags = ($urandom_range(99) < 92) ? 4'hF : 4'($urandom);
        key = ($urandom_range(99) < 93) ? key_pool[$urandom_range(NUM_KEYS-1)]
                                        : {$urandom, $urandom};
        r = mk(key, flags,
               ($urandom_range(99) < 70) ? 32'($urandom_range(3)) : 32'($urandom),
               ($urandom_range(99) < 80) ? 32'($urandom_range(1)) : 32'($urandom),
               ($urandom_range(99) < 80) ? 32'($urandom_range(1)) : 32'($urandom),
               ($urandom_range(99) < 15) ? ALL32 - $urandom_range(2000000) : $urandom);
        return r;
    endfunction

    // append one request to the driver queue
    task automatic enqueue(t_req r);
        pending_q.insert(pending_q.size(), r);
    endtask

    task automatic chk(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    // driver: present the next item at the falling edge
    always @(negedge i_clk) begin
        t_req r;
        if (i_rst_n && !(i_start && !took_item)) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                r = pending_q.pop_front();
                i_subject_key <= r.key;
                i_domain_present <= r.dom;
                i_scope_present <= r.scp;
                i_ids_present <= r.ids;
                i_step_present <= r.stp;
                i_epoch <= r.epoch;
                i_incarnation <= r.inc;
                i_fence_token <= r.fence;
                i_requester_step <= r.step;
                i_policy_generation <= r.pol;
                i_requested_at <= r.req_at;
                i_start <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // monitor: predict on accept, check on result strobe, watchdog
    always @(posedge i_clk) begin
        t_req r;
        t_verdict v;
        if (i_rst_n) begin
            took_item <= i_start && !o_busy;
            if (i_start && !o_busy) begin
                r = '{key: i_subject_key, dom: i_domain_present, scp: i_scope_present,
                      ids: i_ids_present, stp: i_step_present, epoch: i_epoch,
                      inc: i_incarnation, fence: i_fence_token, step: i_requester_step,
                      pol: i_policy_generation, req_at: i_requested_at};
                verdict_q.insert(verdict_q.size(), witness_verdict(r));
            end
            if (o_result_valid) begin
                if (verdict_q.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    v = verdict_q.pop_front();
                    chk("status_code", 32'(v.status), 32'(o_status_code));
                    chk("detail", v.detail, o_detail);
                    chk("subject_generation", v.gen, o_subject_generation);
                    chk("attest_seq", v.seq, o_attest_seq);
                    chk("window_start", v.issued, o_window_start);
                    chk("window_end", v.win_end, o_window_end);
                    chk("policy_generation_out", v.pol, o_policy_generation_out);
                    chk("echo_time", v.observed, o_echo_time);
                end
            end
            if ((i_start && !o_busy) || o_result_valid || (i_cfg_valid && o_cfg_ready))
                stall_cnt <= 0;
            else if (stall_cnt >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else
                stall_cnt <= stall_cnt + 1;
        end
    end

    task automatic drain_wait();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_q.size() != 0 || i_start || verdict_q.size() != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [HOR_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_HORIZON) horizon_reg = data;
        else if (idx == CFG_MAX_SUBJ) subj_limit_reg = data[10:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i == n / 3) idle_pct = 60;
            if (i == 2 * n / 3) idle_pct = 0;
            if (i == n / 3 || i == 2 * n / 3) drain_wait();
            enqueue(rand_req());
        end
        drain_wait();
    endtask

    initial begin
        logic [63:0] ka, kb;
        for (int i = 0; i < NUM_KEYS; i++) key_pool[i] = {$urandom, $urandom};
        key_pool[0] = '0;
        key_pool[1] = '1;
        ka = key_pool[2];
        kb = key_pool[3];
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: presence flags, conflicts, regression, window saturation
        idle_pct = 23;
        enqueue(mk(ka, 4'b0111, 1, 1, 1, 5));
        enqueue(mk(ka, 4'b1011, 1, 1, 1, 5));
        enqueue(mk(ka, 4'b1101, 1, 1, 1, 5));
        enqueue(mk(ka, 4'b1110, 1, 1, 1, 5));
        enqueue(mk(ka, 4'b0000, 1, 1, 1, 5));
        enqueue(mk(ka, 4'hF, 5, 7, 9, 0));
        enqueue(mk(ka, 4'hF, 5, 7, 9, 100));
        enqueue(mk(ka, 4'hF, 4, 7, 9, 100));
        enqueue(mk(ka, 4'hF, 5, 8, 9, 100));
        enqueue(mk(ka, 4'hF, 5, 7, 10, 100));
        enqueue(mk(ka, 4'hF, 6, 1, 2, ALL32));
        enqueue(mk(ka, 4'hF, 6, 1, 2, ALL32 - 1000));
        enqueue(mk(key_pool[0], 4'hF, 0, 0, 0, 0));
        enqueue(mk(key_pool[1], 4'hF, ALL32, ALL32, ALL32, ALL32));
        enqueue(mk(key_pool[1], 4'hF, 0, 0, 0, 0));
        enqueue(mk(key_pool[1], 4'hF, ALL32, 0, ALL32, 1));
        enqueue(mk(key_pool[1], 4'hF, ALL32, ALL32, 0, 1));
        drain_wait();

        // zero horizon, tight subject limit: new keys refused as full once the limit is reached
        cfg_write(CFG_HORIZON, 21'd0);
        cfg_write(CFG_MAX_SUBJ, 21'd4);
        enqueue(mk(kb, 4'hF, 1, 1, 1, 50));
        enqueue(mk(key_pool[4], 4'hF, 1, 1, 1, 50));
        enqueue(mk(ka, 4'hF, 7, 1, 1, 50));
        drain_wait();
        cfg_write(CFG_MAX_SUBJ, 21'd0);
        enqueue(mk(key_pool[5], 4'hF, 1, 1, 1, 50));
        drain_wait();

        // random phases across register settings
        idle_pct = 23;
        cfg_write(CFG_HORIZON, 21'h1F_FFFF);
        cfg_write(CFG_MAX_SUBJ, 21'h7FF);
        run_random(500);
        idle_pct = 23;
        cfg_write(CFG_HORIZON, 21'd1);
        cfg_write(CFG_MAX_SUBJ, 21'd0);
        run_random(300);
        idle_pct = 23;
        cfg_write(CFG_HORIZON, 21'(HORIZON_MAX));
        cfg_write(CFG_MAX_SUBJ, 21'd30);
        run_random(400);
        idle_pct = 23;
        cfg_write(CFG_HORIZON, 21'($urandom));
        cfg_write(CFG_MAX_SUBJ, 21'($urandom_range(80, 2047)));
        run_random(400);
        idle_pct = 23;
        cfg_write(CFG_HORIZON, 21'($urandom_range(HORIZON_MAX)));
        cfg_write(CFG_MAX_SUBJ, 21'(TABLE_DEPTH));
        run_random(300);

        if (errors == 0 && verdict_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/epfw_pkg.sv
rtl/epfw_ram.sv
rtl/epoch_fence_witness_table_top.sv
rtl/epfw_checker.sv
tb/epoch_fence_witness_table_top_test.sv
